FILE: hdl/bffa_pkg.sv
// Package with shared types and constants of the best-fit free block allocator.
package bffa_pkg;
    localparam int LIST_DEPTH = 200;
    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int ENT_W = 62;

    localparam logic CFG_DELETION_ENABLED = 1'b0;
    localparam logic CFG_START_OFFSET     = 1'b1;

    localparam logic ACT_RELEASE  = 1'b0;
    localparam logic ACT_ALLOCATE = 1'b1;

    typedef struct packed {
        logic        action;
        logic [30:0] block_position;
        logic [30:0] block_length;
    } t_in_word;

    typedef struct packed {
        logic [30:0] alloc_position;
        logic        from_free_list;
        logic        overflowed;
        logic [7:0]  free_entries;
    } t_out_word;

    typedef struct packed {
        logic [30:0] pos;
        logic [30:0] len;
    } t_entry;
endpackage

FILE: hdl/bffa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

FILE: hdl/best_fit_free_block_allocator_top.sv
// Top level of the best-fit free block allocator: sequencer around the list memory.
//
// Usage: an input word (action, position, length) is taken on i_in_valid with
// o_in_stall low. If deletion is enabled and the list has room, a release inserts a free
// block into a length-sorted list; an allocate takes the first entry long enough or
// falls back to the append pointer. Exactly one output word follows every input word.
//
// The list lives in one RAM with registered reads. Scanning and shifting read
// ahead, so they move one entry per cycle. The next word is taken only after the
// output word is taken, so words are handled one at a time.
//
// Reset (i_rst_n low, synchronous) empties the list, clears the overflow flag
// and bounds, and loads the append pointer with start_offset's reset value.
// The memory needs no clearing; only live entries are read.
// A finished word sits in the output register until taken; a stalled receiver
// holds it and the block takes no further item until it drains.
module best_fit_free_block_allocator_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bffa_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bffa_pkg::t_out_word o_out_data,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [30:0]         i_cfg_data
);
    import bffa_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHUP  = 3'd2;
    localparam logic [2:0] S_SHDN  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]       r_state;
    logic             r_del_en;
    logic [CNT_W-1:0] r_count;
    logic [30:0]      r_min, r_max, r_app;
    logic             r_ovf;
    logic             r_act;
    logic [30:0]      r_pos, r_len;
    logic [CNT_W-1:0] r_at, r_k;
    logic             r_rd_pend;
    logic             r_tail;
    logic [30:0]      r_res_pos;
    logic             r_reused;
    logic             r_out_valid;
    t_out_word        r_out;

    logic             we;
    logic [IDX_W-1:0] waddr, raddr;
    t_entry           wdata, rdata;

    bffa_ram #(.WIDTH(ENT_W), .DEPTH(LIST_DEPTH)) u_list (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    logic accept;
    assign accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE) || r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

    // While r_rd_pend is high, rdata holds the entry next to be used and the
    // following one is already being read.
    logic [CNT_W-1:0] rd_idx;
    always_comb begin
        rd_idx = r_k;
        if (r_state == S_SCAN) begin
            rd_idx = r_rd_pend ? r_k + CNT_W'(1) : r_k;
        end else if (r_state == S_SHDN) begin
            rd_idx = r_rd_pend ? r_k + CNT_W'(2) : r_k + CNT_W'(1);
        end else if (r_state == S_SHUP) begin
            rd_idx = r_rd_pend ? r_k - CNT_W'(2) : r_k - CNT_W'(1);
        end
    end
    assign raddr = rd_idx[IDX_W-1:0];

    logic [30:0] tail_len;
    assign tail_len = rdata.len - r_len;

    logic scan_end, scan_hit, shdn_end;
    assign scan_end = (r_k == r_count);
    assign scan_hit = !scan_end && r_rd_pend && !(r_len > rdata.len);
    assign shdn_end = (r_k + CNT_W'(1) >= r_count);

    always_comb begin
        we = 1'b0;
        waddr = r_k[IDX_W-1:0];
        wdata = rdata;
        if (r_state == S_SHDN && r_rd_pend && !shdn_end) begin
            we = 1'b1;
        end
        if (r_state == S_SHUP) begin
            if (r_k == r_at) begin
                we = 1'b1;
                wdata = '{pos: r_pos, len: r_len};
            end else if (r_rd_pend) begin
                we = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_del_en <= 1'b1;
            r_count <= '0;
            r_min <= '0;
            r_max <= '0;
            r_app <= '0;
            r_ovf <= 1'b0;
            r_out_valid <= 1'b0;
            r_rd_pend <= 1'b0;
            r_k <= '0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_DELETION_ENABLED: r_del_en <= i_cfg_data[0];
                    CFG_START_OFFSET:     r_app <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_act <= i_in_data.action;
                        r_pos <= i_in_data.block_position;
                        r_len <= i_in_data.block_length;
                        r_k <= '0;
                        r_rd_pend <= 1'b0;
                        r_res_pos <= '0;
                        r_reused <= 1'b0;
                        r_tail <= 1'b0;
                        if (i_in_data.action == ACT_RELEASE) begin
                            if (!r_del_en) begin
                                r_state <= S_DONE;
                            end else if (r_count >= CNT_W'(LIST_DEPTH)) begin
                                r_ovf <= 1'b1;
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end else if (r_del_en && r_count != '0 &&
                                     r_max >= i_in_data.block_length) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_res_pos <= r_app;
                            r_app <= r_app + i_in_data.block_length;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_act == ACT_RELEASE && (scan_end || scan_hit)) begin
                        // The slot is found; the bounds follow an insert at either end.
                        r_at <= r_k;
                        if (r_k == '0) r_min <= r_len;
                        if (scan_end) r_max <= r_len;
                        r_k <= r_count;
                        r_rd_pend <= 1'b0;
                        r_state <= S_SHUP;
                    end else if (scan_end) begin
                        // Allocation with no fitting entry.
                        r_res_pos <= r_app;
                        r_app <= r_app + r_len;
                        r_state <= S_DONE;
                    end else if (scan_hit) begin
                        // The entry after the hit is already being read for the removal.
                        r_res_pos <= rdata.pos;
                        r_reused <= 1'b1;
                        r_pos <= rdata.pos + r_len;
                        r_len <= tail_len;
                        r_tail <= (tail_len >= r_min);
                        r_state <= S_SHDN;
                    end else if (!r_rd_pend) begin
                        r_rd_pend <= 1'b1;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_SHUP: begin
                    if (r_k == r_at) begin
                        r_count <= r_count + 1'b1;
                        r_rd_pend <= 1'b0;
                        r_state <= S_DONE;
                    end else if (!r_rd_pend) begin
                        r_rd_pend <= 1'b1;
                    end else begin
                        r_k <= r_k - 1'b1;
                    end
                end
                S_SHDN: begin
                    if (shdn_end) begin
                        r_count <= r_count - 1'b1;
                        r_rd_pend <= 1'b0;
                        if (r_tail) begin
                            // Remove then insert: start over with the tail as a release.
                            r_act <= ACT_RELEASE;
                            r_tail <= 1'b0;
                            r_k <= '0;
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else if (!r_rd_pend) begin
                        r_rd_pend <= 1'b1;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_DONE: begin
                    r_out_valid <= 1'b1;
                    r_out.alloc_position <= r_res_pos;
                    r_out.from_free_list <= r_reused;
                    r_out.overflowed <= r_ovf;
                    r_out.free_entries <= 8'(r_count);
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: hdl/bffa_checker.sv
// Port-level checker for the best-fit free block allocator, bound to the top level.
module bffa_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input bffa_pkg::t_out_word o_out_data
);
    import bffa_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output word changed");

    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while output pending");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word taken before result");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.overflowed && !i_out_stall
        |=> ##1 !o_out_valid || o_out_data.overflowed)
        else $error("overflow flag cleared");
endmodule

bind best_fit_free_block_allocator_top bffa_checker u_bffa_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_stall(o_in_stall), .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall), .o_out_data(o_out_data)
);

FILE: dv/tb_best_fit_free_block_allocator_top.sv
// Testbench for the best-fit free block allocator: random and directed words checked against a predictor.
module tb_best_fit_free_block_allocator_top;
    import bffa_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_word  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_word o_out_data;
    logic      i_cfg_we;
    logic      i_cfg_index;
    logic [30:0] i_cfg_data;

    best_fit_free_block_allocator_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Predictor state.
    logic        pr_enabled;
    logic [30:0] pr_pos [LIST_DEPTH];
    logic [30:0] pr_len [LIST_DEPTH];
    int          pr_count;
    logic [30:0] pr_min;
    logic [30:0] pr_max;
    logic [30:0] pr_append;
    logic        pr_ovf;

    t_in_word  pending_words[$];
    t_out_word expected_words[$];
    int        error_count;
    bit        quiet_mode;
    bit        hold_receiver;
    bit        hold_start;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic void list_insert(input logic [30:0] p, input logic [30:0] l);
        int at;
        at = 0;
        if (!pr_enabled) return;
        if (pr_count >= LIST_DEPTH) begin
            pr_ovf = 1'b1;
            return;
        end
        while (at < pr_count && l > pr_len[at]) at++;
        if (at == 0) pr_min = l;
        if (at == pr_count) pr_max = l;
        for (int k = pr_count; k > at; k--) begin
            pr_pos[k] = pr_pos[k-1];
            pr_len[k] = pr_len[k-1];
        end
        pr_pos[at] = p;
        pr_len[at] = l;
        pr_count++;
    endfunction

    function automatic t_out_word predict_alloc(input t_in_word w);
        t_out_word r;
        int at;
        bit found;
        logic [30:0] tail_len;
        logic [30:0] tail_pos;
        r = '0;
        at = 0;
        found = 0;
        if (w.action == ACT_RELEASE) begin
            list_insert(w.block_position, w.block_length);
        end else begin
            if (pr_enabled && pr_count != 0 && pr_max >= w.block_length) begin
                while (at < pr_count && w.block_length > pr_len[at]) at++;
                found = at < pr_count;
            end
            if (!found) begin
                r.alloc_position = pr_append;
                pr_append = pr_append + w.block_length;
            end else begin
                r.alloc_position = pr_pos[at];
                r.from_free_list = 1'b1;
                tail_len = pr_len[at] - w.block_length;
                tail_pos = pr_pos[at] + w.block_length;
                for (int k = at; k + 1 < pr_count; k++) begin
                    pr_pos[k] = pr_pos[k+1];
                    pr_len[k] = pr_len[k+1];
                end
                pr_count--;
                if (tail_len >= pr_min)
                    list_insert(tail_pos, tail_len);
            end
        end
        r.overflowed = pr_ovf;
        r.free_entries = pr_count[7:0];
        return r;
    endfunction

    task automatic queue_word(input logic act, input logic [30:0] p, input logic [30:0] l);
        t_in_word w;
        w.action = act;
        w.block_position = p;
        w.block_length = l;
        pending_words = {pending_words, w};
    endtask

    function automatic logic [30:0] rand_len();
        unique case ($urandom_range(0, 9))
            0: return 31'($urandom);
            1: return 31'h7fffffff;
            2: return 31'd0;
            default: return 31'($urandom_range(1, 64));
        endcase
    endfunction

    // Driver: offers words from the pending queue, with random gaps.
    int send_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall)
                expected_words = {expected_words, predict_alloc(i_in_data)};
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= pending_words.pop_front();
                    if (!quiet_mode && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 17);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each taken word and applies random stalls.
    int stall_left;
    t_out_word exp_w;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $error("output word with nothing expected");
                    error_count++;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (o_out_data.alloc_position !== exp_w.alloc_position) begin
                        $error("alloc_position exp %0d got %0d",
                               exp_w.alloc_position, o_out_data.alloc_position);
                        error_count++;
                    end
                    if (o_out_data.from_free_list !== exp_w.from_free_list) begin
                        $error("from_free_list exp %0d got %0d",
                               exp_w.from_free_list, o_out_data.from_free_list);
                        error_count++;
                    end
                    if (o_out_data.overflowed !== exp_w.overflowed) begin
                        $error("overflowed exp %0d got %0d",
                               exp_w.overflowed, o_out_data.overflowed);
                        error_count++;
                    end
                    if (o_out_data.free_entries !== exp_w.free_entries) begin
                        $error("free_entries exp %0d got %0d",
                               exp_w.free_entries, o_out_data.free_entries);
                        error_count++;
                    end
                end
            end
            if (hold_receiver) begin
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 17) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Long receiver hold, counted here while the sender keeps offering words.
    initial begin
        hold_receiver = 0;
        wait (hold_start);
        hold_receiver = 1;
        repeat (600) @(posedge i_clk);
        hold_receiver = 0;
    end

    task automatic write_reg(input logic idx, input logic [30:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_DELETION_ENABLED) begin
            pr_enabled = val[0];
        end else begin
            pr_append = val;
        end
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || expected_words.size() != 0 || i_in_valid)
            @(posedge i_clk);
        // Worst case: a full scan plus shift over the list.
        repeat (2 * LIST_DEPTH + 20) @(posedge i_clk);
    endtask

    // Random mix of releases and allocations, release_pct percent of them releases, mostly with small lengths.
    task automatic random_phase(input int n, input int release_pct);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < release_pct)
                queue_word(ACT_RELEASE, 31'($urandom), rand_len());
            else
                queue_word(ACT_ALLOCATE, 31'($urandom), rand_len());
        end
    endtask

    initial begin
        error_count = 0;
        quiet_mode = 0;
        hold_start = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_DELETION_ENABLED;
        i_cfg_data = '0;
        pr_enabled = 1'b1;
        pr_count = 0;
        pr_min = '0;
        pr_max = '0;
        pr_append = '0;
        pr_ovf = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, exact fit, split, zero tail, stale bounds, wrap.
        queue_word(ACT_ALLOCATE, 31'h7fffffff, 31'h7fffffff);
        queue_word(ACT_RELEASE, 31'd100, 31'd10);
        queue_word(ACT_RELEASE, 31'd200, 31'd5);
        queue_word(ACT_RELEASE, 31'h7fffffff, 31'd20);
        queue_word(ACT_ALLOCATE, 31'd0, 31'd5);
        queue_word(ACT_ALLOCATE, 31'd0, 31'd7);
        queue_word(ACT_ALLOCATE, 31'd0, 31'd3);
        queue_word(ACT_ALLOCATE, 31'd0, 31'd20);
        queue_word(ACT_ALLOCATE, 31'd0, 31'd21);
        queue_word(ACT_RELEASE, 31'd0, 31'd0);
        queue_word(ACT_ALLOCATE, 31'd0, 31'd0);
        queue_word(ACT_RELEASE, 31'd50, 31'h7fffffff);
        queue_word(ACT_ALLOCATE, 31'd0, 31'h7ffffff0);
        drain();

        write_reg(CFG_START_OFFSET, 31'h7ffffff0);
        write_reg(CFG_DELETION_ENABLED, 31'd0);
        queue_word(ACT_RELEASE, 31'd9, 31'd9);
        queue_word(ACT_ALLOCATE, 31'd0, 31'd40);
        queue_word(ACT_ALLOCATE, 31'd0, 31'd1);
        random_phase(40, 40);
        drain();

        write_reg(CFG_DELETION_ENABLED, 31'd1);
        write_reg(CFG_START_OFFSET, 31'd0);
        // Fill the list past its depth to hit overflow, with a long receiver hold.
        random_phase(230, 100);
        hold_start = 1;
        random_phase(300, 45);
        drain();

        write_reg(CFG_START_OFFSET, 31'd12345);
        random_phase(500, 55);
        drain();

        quiet_mode = 1;
        random_phase(180, 50);
        drain();

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule

FILE: filelist.f
hdl/bffa_pkg.sv
hdl/bffa_ram.sv
hdl/best_fit_free_block_allocator_top.sv
hdl/bffa_checker.sv
dv/tb_best_fit_free_block_allocator_top.sv
